### design/hssp_pkg.sv
// ----------------------------------------------------------------------------
// Half-step stepper positioner package
// Shared types, command codes and the coil phase table.
// ----------------------------------------------------------------------------
package hssp_pkg;

    localparam int POSITION_BITS = 16;
    localparam int STEPS_BITS    = 8;
    localparam int COIL_BITS     = 6;

    localparam logic [POSITION_BITS-1:0] COUNT_RESET = POSITION_BITS'(400);

    localparam logic [1:0] MODE_HOMING   = 2'd0;
    localparam logic [1:0] MODE_SHORTEST = 2'd1;
    localparam logic [1:0] MODE_SLICE    = 2'd2;
    localparam logic [1:0] MODE_RELATIVE = 2'd3;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    localparam logic [COIL_BITS-1:0] PHASE_TABLE [8] = '{
        6'h18, 6'h08, 6'h28, 6'h20, 6'h24, 6'h04, 6'h14, 6'h10
    };

    typedef struct packed {
        logic                     opcode;
        logic [1:0]               mode;
        logic                     direction;
        logic [POSITION_BITS-1:0] target_or_count;
        logic                     limit_switch;
    } item_t;

    typedef struct packed {
        logic [2:0]               phase_index;
        logic [POSITION_BITS-1:0] step_position;
        logic [1:0]               active_mode;
        logic                     move_direction;
        logic [POSITION_BITS-1:0] goal_position;
        logic [STEPS_BITS-1:0]    steps_left;
        logic                     running;
    } state_t;

    typedef struct packed {
        logic                     status;
        logic                     done_res;
        logic                     busy_res;
        logic                     stepped;
        logic [POSITION_BITS-1:0] position;
        logic [COIL_BITS-1:0]     coil_pattern;
    } result_t;

endpackage

### design/hssp_step_logic.sv
// ----------------------------------------------------------------------------
// Half-step stepper positioner step logic
// Computes the next controller state and the result for one item.
// ----------------------------------------------------------------------------
module hssp_step_logic (
    input  hssp_pkg::item_t                      item,
    input  hssp_pkg::state_t                     cur,
    input  logic [hssp_pkg::POSITION_BITS-1:0]   position_count,
    output hssp_pkg::state_t                     nxt,
    output hssp_pkg::result_t                    res
);

    localparam int PW = hssp_pkg::POSITION_BITS;

    logic [PW-1:0] count_eff;
    logic [PW-1:0] half_count;
    logic [PW:0]   pos_inc;
    logic [PW-1:0] step_pos;
    logic [2:0]    step_phase;
    logic [PW-1:0] target;
    logic [PW-1:0] diff_up;
    logic [PW-1:0] diff_down;
    logic          stepped;
    logic          done;
    logic          status;

    always_comb
    begin
        count_eff  = (position_count == '0) ? PW'(1) : position_count;
        half_count = count_eff >> 1;
        pos_inc    = {1'b0, cur.step_position} + (PW+1)'(1);
        target     = item.target_or_count;
        diff_up    = target - cur.step_position;
        diff_down  = cur.step_position - target;

        if (cur.move_direction == hssp_pkg::DIR_CCW)
        begin
            step_phase = cur.phase_index - 3'd1;
            step_pos   = (cur.step_position == '0) ? (count_eff - PW'(1))
                                                   : (cur.step_position - PW'(1));
        end
        else
        begin
            step_phase = cur.phase_index + 3'd1;
            step_pos   = (pos_inc >= {1'b0, count_eff}) ? '0 : pos_inc[PW-1:0];
        end

        nxt     = cur;
        stepped = 1'b0;
        done    = 1'b0;
        status  = 1'b0;

        if (item.opcode == hssp_pkg::OP_START)
        begin
            nxt.active_mode    = item.mode;
            nxt.move_direction = item.direction;
            nxt.running        = 1'b1;
            unique case (item.mode)
                hssp_pkg::MODE_HOMING:
                begin
                    if (item.limit_switch)
                    begin
                        nxt.step_position = '0;
                        nxt.running       = 1'b0;
                        done              = 1'b1;
                    end
                end
                hssp_pkg::MODE_RELATIVE:
                begin
                    nxt.steps_left = item.target_or_count[hssp_pkg::STEPS_BITS-1:0];
                    if (nxt.steps_left == '0)
                    begin
                        nxt.running = 1'b0;
                        done        = 1'b1;
                    end
                end
                default:
                begin
                    if (target >= count_eff)
                    begin
                        nxt.running = 1'b0;
                        status      = 1'b1;
                    end
                    else
                    begin
                        nxt.goal_position = target;
                        if (target == cur.step_position)
                        begin
                            nxt.running = 1'b0;
                            done        = 1'b1;
                        end
                        else if (item.mode == hssp_pkg::MODE_SLICE)
                        begin
                            nxt.move_direction = (target > cur.step_position)
                                ? hssp_pkg::DIR_CW : hssp_pkg::DIR_CCW;
                        end
                        else if (target > cur.step_position)
                        begin
                            nxt.move_direction = (diff_up < half_count)
                                ? hssp_pkg::DIR_CW : hssp_pkg::DIR_CCW;
                        end
                        else
                        begin
                            nxt.move_direction = (diff_down < half_count)
                                ? hssp_pkg::DIR_CCW : hssp_pkg::DIR_CW;
                        end
                    end
                end
            endcase
        end
        else if (cur.running)
        begin
            if (cur.active_mode == hssp_pkg::MODE_HOMING && item.limit_switch)
            begin
                nxt.step_position = '0;
                nxt.running       = 1'b0;
                done              = 1'b1;
            end
            else
            begin
                nxt.phase_index   = step_phase;
                nxt.step_position = step_pos;
                stepped           = 1'b1;
                if (cur.active_mode == hssp_pkg::MODE_RELATIVE)
                begin
                    nxt.steps_left = cur.steps_left - 8'd1;
                    if (nxt.steps_left == '0)
                    begin
                        nxt.running = 1'b0;
                        done        = 1'b1;
                    end
                end
                else if (cur.active_mode != hssp_pkg::MODE_HOMING)
                begin
                    if (step_pos == cur.goal_position)
                    begin
                        nxt.running = 1'b0;
                        done        = 1'b1;
                    end
                end
            end
        end

        res.coil_pattern = hssp_pkg::PHASE_TABLE[nxt.phase_index];
        res.position     = nxt.step_position;
        res.stepped      = stepped;
        res.busy_res     = nxt.running;
        res.done_res     = done;
        res.status       = status;
    end

endmodule

### design/half_step_stepper_positioner.sv
// ----------------------------------------------------------------------------
// Half-step stepper positioner
// Drives a half-step stepper through homing, absolute and relative moves.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register; its result is written into
// the result register once the output is free to take it.
// Throughput: one item per cycle unless the output stalls; the state update
// is a combinational path: input register, step logic, state registers.
// Reset: asynchronous, active low; state is zero and idle, the position count
// returns to 400, and both the input and result registers are emptied.
module half_step_stepper_positioner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // mode, direction, target_or_count, limit_switch
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // coil_pattern, position, stepped, busy_res,
                                       // done_res, status
);

    localparam int PW = hssp_pkg::POSITION_BITS;

    logic [PW-1:0]     count_reg;
    hssp_pkg::item_t   in_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    hssp_pkg::state_t  state_reg;
    hssp_pkg::state_t  state_next;
    hssp_pkg::result_t out_reg;
    hssp_pkg::result_t out_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              in_accept;
    logic              advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    hssp_step_logic u_step (
        .item           (in_reg),
        .cur            (state_reg),
        .position_count (count_reg),
        .nxt            (state_next),
        .res            (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= hssp_pkg::COUNT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_reg.opcode          <= s_axis_tuser;
            in_reg.mode            <= s_axis_tdata[1:0];
            in_reg.direction       <= s_axis_tdata[2];
            in_reg.target_or_count <= s_axis_tdata[18:3];
            in_reg.limit_switch    <= s_axis_tdata[19];
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_reg.done_res && out_reg.busy_res))
        else $error("Result shows a command both finished and busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_reg.status |-> !out_reg.busy_res && !out_reg.stepped)
        else $error("Rejected start left a command running or stepped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && out_next.stepped |=> state_reg.phase_index != $past(state_reg.phase_index))
        else $error("Step taken without a phase change.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input stalled while the result register is empty.");

endmodule
